>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge while the synchronous reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)

`endif

`endif

>>> rtl/sawc_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative word cache package
// Widths, request codes and the lookup result type shared by the cache RTL.
// ----------------------------------------------------------------------------
package sawc_pkg;

    // Fixed field widths
    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = 32;
    localparam int OFFSET_BITS = 2;

    // Default geometry
    localparam int SET_BITS_DEF = 4;
    localparam int WAYS_DEF     = 4;

    // Stream payload widths
    localparam int S_DATA_W = ADDR_W + 2 * WORD_W;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = WORD_W + 2 * CNT_W;
    localparam int M_USER_W = 2;

    // Access kind carried in the slave tuser
    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req;

    // Decisions taken for one access by the lookup logic
    typedef struct packed {
        logic hit;
        logic fill;
        logic count_hit;
        logic count_miss;
    } t_lookup;

endpackage

>>> rtl/sawc_way_store.sv
// ----------------------------------------------------------------------------
// Cache way store
// Tag and word memory of one way, with a registered read and write forwarding.
// ----------------------------------------------------------------------------
module sawc_way_store #(
    parameter int SET_BITS = sawc_pkg::SET_BITS_DEF,
    parameter int TAG_W    = sawc_pkg::ADDR_W - sawc_pkg::OFFSET_BITS - sawc_pkg::SET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [SET_BITS-1:0]         i_rd_set,
    input  logic                        i_wr_en,
    input  logic [SET_BITS-1:0]         i_wr_set,
    input  logic [TAG_W-1:0]            i_wr_tag,
    input  logic [sawc_pkg::WORD_W-1:0] i_wr_word,
    output logic [TAG_W-1:0]            o_tag,
    output logic [sawc_pkg::WORD_W-1:0] o_word
);
    import sawc_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS;

    logic [TAG_W-1:0]  r_tag_mem  [NUM_SETS];
    logic [WORD_W-1:0] r_word_mem [NUM_SETS];
    logic [TAG_W-1:0]  r_tag;
    logic [WORD_W-1:0] r_word;

    // Write port: one line per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_set]  <= i_wr_tag;
            r_word_mem[i_wr_set] <= i_wr_word;
        end
    end

    // Read port: a line written at the same edge is forwarded to the reader.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_set == i_rd_set)) begin
                r_tag  <= i_wr_tag;
                r_word <= i_wr_word;
            end else begin
                r_tag  <= r_tag_mem[i_rd_set];
                r_word <= r_word_mem[i_rd_set];
            end
        end
    end

    assign o_tag  = r_tag;
    assign o_word = r_word;

endmodule

>>> rtl/sawc_lookup.sv
// ----------------------------------------------------------------------------
// Cache lookup
// Tag compare over all ways, hit way priority, victim choice and read data.
// ----------------------------------------------------------------------------
module sawc_lookup #(
    parameter int WAYS     = sawc_pkg::WAYS_DEF,
    parameter int TAG_W    = sawc_pkg::ADDR_W - sawc_pkg::OFFSET_BITS - sawc_pkg::SET_BITS_DEF,
    parameter int WAY_BITS = $clog2(sawc_pkg::WAYS_DEF)
) (
    input  sawc_pkg::t_req              i_req,
    input  logic [TAG_W-1:0]            i_tag,
    input  logic [sawc_pkg::WORD_W-1:0] i_write_data,
    input  logic [sawc_pkg::WORD_W-1:0] i_mem_data,
    input  logic [WAYS-1:0]             i_valid,
    input  logic [TAG_W-1:0]            i_way_tag  [WAYS],
    input  logic [sawc_pkg::WORD_W-1:0] i_way_word [WAYS],
    input  logic [WAY_BITS-1:0]         i_victim_base,
    output sawc_pkg::t_lookup           o_res,
    output logic [WAY_BITS-1:0]         o_way,
    output logic [WAY_BITS-1:0]         o_victim_next,
    output logic [sawc_pkg::WORD_W-1:0] o_line_word,
    output logic [sawc_pkg::WORD_W-1:0] o_read_data
);
    import sawc_pkg::*;

    logic [WAYS-1:0]     match;
    logic [WAY_BITS-1:0] hit_way;
    logic                hit;
    logic                is_write;

    // Parallel tag compare against every valid way of the set.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match[w] = i_valid[w] && (i_way_tag[w] == i_tag);
        end
    end

    // The lowest-numbered matching way wins.
    always_comb begin
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WAY_BITS'(w);
            end
        end
    end

    assign hit      = |match;
    assign is_write = (i_req == REQ_WRITE);

    // Round-robin pointer advanced by one, wrapping at the way count.
    assign o_victim_next = (i_victim_base == WAY_BITS'(WAYS - 1)) ? '0
                         : i_victim_base + WAY_BITS'(1);

    // Access decisions.
    always_comb begin
        o_res.hit        = hit;
        o_res.fill       = is_write || !hit;
        o_res.count_hit  = !is_write && hit;
        o_res.count_miss = !is_write && !hit;
    end

    // A write hit updates in place; a write miss uses the pointer as it stands
    // and a read miss uses it after the miss has been counted.
    assign o_way = hit      ? hit_way
                 : is_write ? i_victim_base
                 : o_victim_next;

    assign o_line_word = is_write ? i_write_data : i_mem_data;

    assign o_read_data = is_write ? '0
                       : hit      ? i_way_word[hit_way]
                       : i_mem_data;

endmodule

>>> rtl/set_assoc_word_cache_unit.sv
// ----------------------------------------------------------------------------
// Set-associative word cache unit
// Write-through cache of one word per line with round-robin replacement.
// ----------------------------------------------------------------------------
// Usage:
// Each slave transaction is one access: tuser carries the kind (read or
// write), tdata the address, the write word and the backing memory word.
// Each access gives exactly one master transaction with the read word, the
// hit and memory-write flags and the read hit and miss totals after it.
// The way memories are read as the access is accepted; the tag compare and
// the way selection happen in the next cycle, and the line update and the
// result register load take place as the access leaves the lookup stage.
// One access is taken every cycle while the master side does not stall, as
// the compare over all ways of the set is combinational.
// A stalled master side holds the result register; one more access may then
// wait in the lookup stage, after which tready falls until the result goes.
// Reset clears the line valid bits, both totals and the replacement pointer;
// no clearing pass is needed and an access can be taken right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_word_cache_unit #(
    parameter int SET_BITS = sawc_pkg::SET_BITS_DEF,
    parameter int WAYS     = sawc_pkg::WAYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: addr[31:0], write_data[63:32], mem_data[95:64]
    input  logic [sawc_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: req_type[0]
    input  logic [sawc_pkg::S_USER_W-1:0] i_s_tuser,
    // Master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: read_data[31:0], hit_total[63:32], miss_total[95:64]
    output logic [sawc_pkg::M_DATA_W-1:0] o_m_tdata,
    // tuser: was_hit[0], mem_write[1]
    output logic [sawc_pkg::M_USER_W-1:0] o_m_tuser
);
    import sawc_pkg::*;

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int TAG_W    = ADDR_W - OFFSET_BITS - SET_BITS;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;

    // Lookup stage registers
    logic                r_s1_valid;
    t_req                r_s1_req;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic [WORD_W-1:0]   r_s1_wdata;
    logic [WORD_W-1:0]   r_s1_mdata;

    // Line valid bits, totals and replacement pointer
    logic [NUM_SETS-1:0] r_valid [WAYS];
    logic [CNT_W-1:0]    r_hit_count;
    logic [CNT_W-1:0]    r_miss_count;
    logic [WAY_BITS-1:0] r_victim_base;
    logic [CNT_W-1:0]    n_hit_count;
    logic [CNT_W-1:0]    n_miss_count;

    // Result register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [M_USER_W-1:0] r_m_user;

    logic                s_accept;
    logic                s1_advance;
    logic [SET_BITS-1:0] rd_set;
    logic [SET_BITS-1:0] s1_set;
    logic [TAG_W-1:0]    s1_tag;
    logic [WAYS-1:0]     way_valid;
    logic [WAYS-1:0]     way_wr_en;
    logic [TAG_W-1:0]    way_tag  [WAYS];
    logic [WORD_W-1:0]   way_word [WAYS];

    t_lookup             lk_res;
    logic [WAY_BITS-1:0] lk_way;
    logic [WAY_BITS-1:0] lk_victim_next;
    logic [WORD_W-1:0]   lk_line_word;
    logic [WORD_W-1:0]   lk_read_data;

    // Handshake: the lookup stage moves on whenever the result register frees up.
    assign s1_advance = r_s1_valid && (!r_m_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign rd_set = i_s_tdata[OFFSET_BITS +: SET_BITS];
    assign s1_set = r_s1_addr[OFFSET_BITS +: SET_BITS];
    assign s1_tag = r_s1_addr[ADDR_W-1 -: TAG_W];

    // Lookup stage input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_req   <= t_req'(i_s_tuser[0]);
            r_s1_addr  <= i_s_tdata[ADDR_W-1:0];
            r_s1_wdata <= i_s_tdata[ADDR_W +: WORD_W];
            r_s1_mdata <= i_s_tdata[ADDR_W + WORD_W +: WORD_W];
        end
    end

    // Way memories, read as the access is accepted.
    for (genvar w = 0; w < WAYS; w++) begin : g_way
        assign way_wr_en[w] = s1_advance && lk_res.fill && (lk_way == WAY_BITS'(w));
        assign way_valid[w] = r_valid[w][s1_set];

        sawc_way_store #(
            .SET_BITS (SET_BITS),
            .TAG_W    (TAG_W)
        ) u_way_store (
            .i_clk     (i_clk),
            .i_rd_en   (s_accept),
            .i_rd_set  (rd_set),
            .i_wr_en   (way_wr_en[w]),
            .i_wr_set  (s1_set),
            .i_wr_tag  (s1_tag),
            .i_wr_word (lk_line_word),
            .o_tag     (way_tag[w]),
            .o_word    (way_word[w])
        );
    end

    // Tag compare and way selection.
    sawc_lookup #(
        .WAYS     (WAYS),
        .TAG_W    (TAG_W),
        .WAY_BITS (WAY_BITS)
    ) u_lookup (
        .i_req         (r_s1_req),
        .i_tag         (s1_tag),
        .i_write_data  (r_s1_wdata),
        .i_mem_data    (r_s1_mdata),
        .i_valid       (way_valid),
        .i_way_tag     (way_tag),
        .i_way_word    (way_word),
        .i_victim_base (r_victim_base),
        .o_res         (lk_res),
        .o_way         (lk_way),
        .o_victim_next (lk_victim_next),
        .o_line_word   (lk_line_word),
        .o_read_data   (lk_read_data)
    );

    // Line valid bits: set when a way is filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WAYS; w++) begin
                r_valid[w] <= '0;
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (way_wr_en[w]) begin
                    r_valid[w][s1_set] <= 1'b1;
                end
            end
        end
    end

    // Totals after this access.
    assign n_hit_count  = lk_res.count_hit  ? r_hit_count  + CNT_W'(1) : r_hit_count;
    assign n_miss_count = lk_res.count_miss ? r_miss_count + CNT_W'(1) : r_miss_count;

    // Totals and the pointer, which tracks their sum modulo the way count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_count   <= '0;
            r_miss_count  <= '0;
            r_victim_base <= '0;
        end else if (s1_advance) begin
            r_hit_count  <= n_hit_count;
            r_miss_count <= n_miss_count;
            if (lk_res.count_hit || lk_res.count_miss) begin
                r_victim_base <= lk_victim_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_advance) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_m_data <= {n_miss_count, n_hit_count, lk_read_data};
            r_m_user <= {(r_s1_req == REQ_WRITE), lk_res.hit};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // Checks on the pipeline control and the line update.
    `ASSERT_CLK_RST(a_no_accept_when_blocked, i_clk, i_rst_n,
        (r_s1_valid && r_m_valid && !i_m_tready) |-> !o_s_tready,
        "access accepted while lookup stage is blocked")
    `ASSERT_CLK_RST(a_single_way_write, i_clk, i_rst_n, $onehot0(way_wr_en),
        "more than one way written for one access")
    `ASSERT_CLK_RST(a_totals_hold, i_clk, i_rst_n,
        !s1_advance |=> ($stable(r_hit_count) && $stable(r_miss_count)),
        "totals changed without an access")
    `ASSERT_CLK_RST(a_write_hits_way, i_clk, i_rst_n,
        (s1_advance && lk_res.hit && (r_s1_req == REQ_WRITE)) |=> r_m_user[0] && r_m_user[1],
        "write hit not reported")

endmodule

>>> tb/sawc_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache access checker
// Watches both stream channels of the cache unit. It keeps its own copy of the
// tags, valid bits, words and read totals, works out the reply to every
// accepted access, and compares each reply with the oldest one still waiting.
// ----------------------------------------------------------------------------
module sawc_access_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Access channel as seen at the cache unit
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // tdata: addr[31:0], write_data[63:32], mem_data[95:64]
    input  logic [sawc_pkg::S_DATA_W-1:0] i_s_tdata,
    // tuser: req_type[0]
    input  logic [sawc_pkg::S_USER_W-1:0] i_s_tuser,
    // Reply channel as seen at the cache unit
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: read_data[31:0], hit_total[63:32], miss_total[95:64]
    input  logic [sawc_pkg::M_DATA_W-1:0] i_m_tdata,
    // tuser: was_hit[0], mem_write[1]
    input  logic [sawc_pkg::M_USER_W-1:0] i_m_tuser,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int SET_BITS  = sawc_pkg::SET_BITS_DEF;
    localparam int NUM_WAYS  = sawc_pkg::WAYS_DEF;
    localparam int NUM_LINES = NUM_WAYS << SET_BITS;
    localparam int TAG_LSB   = sawc_pkg::OFFSET_BITS + SET_BITS;
    localparam int TAG_W     = sawc_pkg::ADDR_W - TAG_LSB;
    localparam int W         = sawc_pkg::WORD_W;
    localparam int MAX_SHOWN = 10;

    // One reply of the cache unit
    typedef struct packed {
        logic [W-1:0]                read_data;
        logic                        was_hit;
        logic                        mem_write;
        logic [sawc_pkg::CNT_W-1:0]  hit_total;
        logic [sawc_pkg::CNT_W-1:0]  miss_total;
    } t_reply;

    // Shadow copy of the cache contents and the read totals
    logic [TAG_W-1:0]           line_tag   [NUM_LINES];
    logic                       line_valid [NUM_LINES];
    logic [W-1:0]               line_word  [NUM_LINES];
    logic [sawc_pkg::CNT_W-1:0] hit_count;
    logic [sawc_pkg::CNT_W-1:0] miss_count;

    t_reply awaited_replies[$];
    int     failures = 0;

    // Applies one access to the shadow cache and returns the reply it must give.
    function automatic t_reply predict_access(input sawc_pkg::t_req kind,
                                              input logic [31:0] addr,
                                              input logic [W-1:0] wdata,
                                              input logic [W-1:0] mdata);
        logic [TAG_W-1:0]           tag;
        logic [sawc_pkg::CNT_W-1:0] count_sum;
        int                         base;
        int                         found;
        int                         victim;
        int                         way;
        t_reply                     reply;
        tag   = addr[sawc_pkg::ADDR_W-1:TAG_LSB];
        base  = int'(addr[TAG_LSB-1:sawc_pkg::OFFSET_BITS]) * NUM_WAYS;
        found = -1;
        // The lowest matching valid way wins, so scan downwards.
        for (way = NUM_WAYS - 1; way >= 0; way--) begin
            if (line_valid[base + way] && line_tag[base + way] == tag) begin
                found = base + way;
            end
        end
        reply           = '0;
        reply.was_hit   = (found >= 0);
        reply.mem_write = (kind == sawc_pkg::REQ_WRITE);
        if (kind == sawc_pkg::REQ_WRITE) begin
            // Write-through: update a matching line, or else claim the round-robin way.
            if (found >= 0) begin
                line_word[found] = wdata;
            end else begin
                count_sum = hit_count + miss_count;
                victim    = int'(count_sum % NUM_WAYS);
                line_valid[base + victim] = 1'b1;
                line_tag[base + victim]   = tag;
                line_word[base + victim]  = wdata;
            end
        end else if (found >= 0) begin
            reply.read_data = line_word[found];
            hit_count       = hit_count + 1'b1;
        end else begin
            // The miss is counted before the victim way is chosen.
            miss_count      = miss_count + 1'b1;
            reply.read_data = mdata;
            count_sum       = hit_count + miss_count;
            victim          = int'(count_sum % NUM_WAYS);
            line_valid[base + victim] = 1'b1;
            line_tag[base + victim]   = tag;
            line_word[base + victim]  = mdata;
        end
        reply.hit_total  = hit_count;
        reply.miss_total = miss_count;
        return reply;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            end
        end
    endtask

    // Check each reply transaction, then record the prediction for each access.
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid[i] = 1'b0;
            end
            hit_count  = '0;
            miss_count = '0;
            awaited_replies.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.read_data  = i_m_tdata[W-1:0];
                got.hit_total  = i_m_tdata[2*W-1:W];
                got.miss_total = i_m_tdata[3*W-1:2*W];
                got.was_hit    = i_m_tuser[0];
                got.mem_write  = i_m_tuser[1];
                if (awaited_replies.size() == 0) begin
                    failures++;
                    if (failures <= MAX_SHOWN) begin
                        $display("unexpected reply: tdata %h, tuser %b", i_m_tdata, i_m_tuser);
                    end
                end else begin
                    want = awaited_replies.pop_front();
                    compare_field("read_data", want.read_data, got.read_data);
                    compare_field("was_hit", 32'(want.was_hit), 32'(got.was_hit));
                    compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
                    compare_field("hit_total", want.hit_total, got.hit_total);
                    compare_field("miss_total", want.miss_total, got.miss_total);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_replies.push_back(predict_access(sawc_pkg::t_req'(i_s_tuser[0]),
                                                         i_s_tdata[31:0],
                                                         i_s_tdata[2*W-1:W],
                                                         i_s_tdata[3*W-1:2*W]));
            end
        end
        o_fail_count <= failures;
        o_pending    <= awaited_replies.size();
    end

endmodule

>>> tb/tb_set_assoc_word_cache_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative word cache unit testbench
// Drives directed and then random read and write accesses into the cache with
// random idle cycles on the access side and random stalls on the reply side,
// and gives the verdict from the failure count of the access checker.
// ----------------------------------------------------------------------------
module tb_set_assoc_word_cache_unit;

    localparam int ITEM_COUNT = 1400;
    localparam int BLOCK_LEN  = 100;
    localparam int POOL_SIZE  = 8;
    localparam int SET_BITS   = sawc_pkg::SET_BITS_DEF;
    localparam int TAG_LSB    = sawc_pkg::OFFSET_BITS + SET_BITS;
    localparam int TAG_W      = sawc_pkg::ADDR_W - TAG_LSB;
    localparam int MAX_GAP    = 5;
    localparam int DRAIN_WAIT = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Access side
    logic                          s_tvalid = 1'b0;
    wire                           s_tready;
    logic [sawc_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [sawc_pkg::S_USER_W-1:0] s_tuser  = '0;

    // Reply side
    wire                           m_tvalid;
    logic                          m_tready = 1'b0;
    wire  [sawc_pkg::M_DATA_W-1:0] m_tdata;
    wire  [sawc_pkg::M_USER_W-1:0] m_tuser;

    int   fail_count;
    int   pending;
    bit   no_idle = 1'b0;

    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    set_assoc_word_cache_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    sawc_access_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard limit on the run, many times the slowest correct run.
    initial begin
        #400_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] make_addr(input logic [TAG_W-1:0] tag,
                                              input int set_index,
                                              input logic [1:0] low_bits);
        return {tag, SET_BITS'(set_index), low_bits};
    endfunction

    // Presents one access after a random idle gap and waits for its transaction.
    task automatic issue_access(input sawc_pkg::t_req kind, input logic [31:0] addr,
                                input logic [31:0] wdata, input logic [31:0] mdata);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mdata, wdata, addr};
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
    endtask

    // Reply side: a random stall before each reply transaction.
    initial begin
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Reset, directed accesses, random accesses, drain and verdict.
    initial begin
        sawc_pkg::t_req kind;
        logic [31:0]    addr;
        int             pick;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            tag_pool[i] = TAG_W'($urandom());
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Cold miss, hit, write miss and a read hit on the written line at the address extremes.
        issue_access(sawc_pkg::REQ_READ, 32'h0000_0000, '0, 32'hffff_ffff);
        issue_access(sawc_pkg::REQ_READ, 32'h0000_0000, '1, 32'h0000_0000);
        issue_access(sawc_pkg::REQ_WRITE, 32'hffff_ffff, 32'h0000_0000, '1);
        issue_access(sawc_pkg::REQ_READ, 32'hffff_fffc, '0, 32'h1234_5678);
        // The two low address bits play no part in the lookup.
        issue_access(sawc_pkg::REQ_WRITE, 32'h0000_0003, 32'ha5a5_a5a5, '0);
        issue_access(sawc_pkg::REQ_READ, 32'h0000_0001, '0, '0);
        // More tags than ways in one set, so the round-robin way evicts lines.
        for (int t = 0; t < 6; t++) begin
            issue_access(sawc_pkg::REQ_READ, make_addr(tag_pool[t], 5, 2'b00), '0,
                         $urandom());
        end
        for (int t = 0; t < 3; t++) begin
            issue_access(sawc_pkg::REQ_READ, make_addr(tag_pool[t], 5, 2'b10), '0,
                         $urandom());
        end
        issue_access(sawc_pkg::REQ_WRITE, make_addr(tag_pool[6], 5, 2'b00), $urandom(), '0);
        issue_access(sawc_pkg::REQ_READ, make_addr(tag_pool[6], 5, 2'b00), '0, $urandom());
        issue_access(sawc_pkg::REQ_WRITE, make_addr(tag_pool[5], 5, 2'b01), $urandom(), '0);
        issue_access(sawc_pkg::REQ_READ, make_addr(tag_pool[5], 5, 2'b00), '0, $urandom());

        // Random accesses, mostly over a small pool of tags so that lines are reused.
        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n % BLOCK_LEN == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            kind = ($urandom_range(0, 99) < 35) ? sawc_pkg::REQ_WRITE : sawc_pkg::REQ_READ;
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                addr = make_addr(tag_pool[$urandom_range(0, POOL_SIZE - 1)],
                                 $urandom_range(0, (1 << SET_BITS) - 1),
                                 2'($urandom()));
            end else begin
                addr = $urandom();
            end
            issue_access(kind, addr, $urandom(), $urandom());
        end
        s_tvalid <= 1'b0;

        // Wait for every awaited reply, and then for anything stray.
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
